// ===== sv/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared constants and helpers for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // action codes on the line channel
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // width of one packed command between front and back for n coordinate bits:
  // three flags, three (n+1) walk fields, decision and NE step (n+3),
  // E step (n+2) and the pivot row (n)
  function automatic int cmd_bits(input int n);
    return 7 * n + 14;
  endfunction

endpackage

// ===== sv/mlr_line_if.sv =====
// ----------------------------------------------------------------------------
// mlr_line_if
// Line command channel: load a line or request its next pixel.
// ----------------------------------------------------------------------------
interface mlr_line_if #(parameter int N = mlr_pkg::COORD_BITS_DEF);
  logic         valid;
  logic         ready;
  logic         action;
  logic [N-1:0] x_start;
  logic [N-1:0] x_end;
  logic [N-1:0] y_start;
  logic [N-1:0] y_end;

  modport source (output valid, action, x_start, x_end, y_start, y_end, input ready);
  modport sink   (input valid, action, x_start, x_end, y_start, y_end, output ready);
endinterface

// ===== sv/mlr_pixel_if.sv =====
// ----------------------------------------------------------------------------
// mlr_pixel_if
// Pixel result channel.
// ----------------------------------------------------------------------------
interface mlr_pixel_if #(parameter int N = mlr_pkg::COORD_BITS_DEF);
  logic         valid;
  logic         ready;
  logic         pixel_valid;
  logic [N-1:0] pixel_x;
  logic [N-1:0] pixel_y;
  logic         last;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== sv/mlr_front.sv =====
// ----------------------------------------------------------------------------
// mlr_front
// Accepts line commands, orders endpoints, folds the line into the first
// octant and builds the walk setup. One register stage: ordering/deltas are
// registered, then slope test and decision seed are formed ahead of the queue.
// ----------------------------------------------------------------------------
module mlr_front #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  mlr_line_if.sink                                  line_in,
  output logic                                      cmd_valid,
  output logic [mlr_pkg::cmd_bits(COORD_BITS)-1:0]  cmd,
  input  logic                                      cmd_ready
);
  import mlr_pkg::*;

  localparam int N = COORD_BITS;

  typedef struct packed {
    logic                is_load;
    logic                steep;
    logic                downward;
    logic [N:0]          walk_major;
    logic [N:0]          walk_minor;
    logic [N:0]          major_end;
    logic signed [N+2:0] decision;
    logic signed [N+1:0] step_east;
    logic signed [N+2:0] step_northeast;
    logic [N-1:0]        mirror_pivot;
  } cmd_t;

  // stage A results
  logic         a_valid;
  logic         a_is_load;
  logic         a_down;
  logic [N-1:0] a_x0;
  logic [N-1:0] a_y0;
  logic [N-1:0] a_dx;
  logic [N-1:0] a_dy;

  logic         swap;
  logic [N-1:0] x0, x1, y0, y1;
  logic         down;
  logic         a_ready;

  always_comb begin
    swap = line_in.x_start > line_in.x_end;
    x0   = swap ? line_in.x_end   : line_in.x_start;
    x1   = swap ? line_in.x_start : line_in.x_end;
    y0   = swap ? line_in.y_end   : line_in.y_start;
    y1   = swap ? line_in.y_start : line_in.y_end;
    down = y0 > y1;
  end

  assign a_ready       = !a_valid || cmd_ready;
  assign line_in.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= line_in.valid;
    end
    if (a_ready && line_in.valid) begin
      a_is_load <= (line_in.action == ACT_LOAD);
      a_down    <= down;
      a_x0      <= x0;
      a_y0      <= y0;
      a_dx      <= x1 - x0;
      // mirrored about the start row, the rise is y0 - y1 downward, else y1 - y0
      a_dy      <= down ? (y0 - y1) : (y1 - y0);
    end
  end

  // stage B: slope test and decision seed
  cmd_t         c;
  logic         steep;
  logic [N-1:0] dmajor;
  logic [N-1:0] dminor;

  always_comb begin
    steep            = a_dy > a_dx;
    dmajor           = steep ? a_dy : a_dx;
    dminor           = steep ? a_dx : a_dy;
    c.is_load        = a_is_load;
    c.steep          = steep;
    c.downward       = a_down;
    c.walk_major     = steep ? {1'b0, a_y0} : {1'b0, a_x0};
    c.walk_minor     = steep ? {1'b0, a_x0} : {1'b0, a_y0};
    c.major_end      = steep ? ({1'b0, a_y0} + {1'b0, a_dy}) : ({1'b0, a_x0} + {1'b0, a_dx});
    c.decision       = $signed({3'b000, dminor}) - $signed({4'b0000, dmajor[N-1:1]});
    c.step_east      = $signed({2'b00, dminor});
    c.step_northeast = $signed({3'b000, dminor}) - $signed({3'b000, dmajor});
    c.mirror_pivot   = a_y0;
  end

  assign cmd_valid = a_valid;
  assign cmd       = c;

endmodule

// ===== sv/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// mlr_queue
// Small FIFO decoupling the setup front from the pixel walker.
// ----------------------------------------------------------------------------
module mlr_queue #(
  parameter int WIDTH = mlr_pkg::cmd_bits(mlr_pkg::COORD_BITS_DEF),
  parameter int DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import mlr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = count < CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== sv/mlr_back.sv =====
// ----------------------------------------------------------------------------
// mlr_back
// Pixel walker: holds the octant-normalized walk, takes one E/NE step for each
// step command while busy, maps the pixel back to screen space, registers it.
// ----------------------------------------------------------------------------
module mlr_back #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cmd_valid,
  input  logic [mlr_pkg::cmd_bits(COORD_BITS)-1:0]  cmd,
  output logic                                      cmd_ready,
  mlr_pixel_if.source                               pixel_out
);
  import mlr_pkg::*;

  localparam int N = COORD_BITS;

  typedef struct packed {
    logic                is_load;
    logic                steep;
    logic                downward;
    logic [N:0]          walk_major;
    logic [N:0]          walk_minor;
    logic [N:0]          major_end;
    logic signed [N+2:0] decision;
    logic signed [N+1:0] step_east;
    logic signed [N+2:0] step_northeast;
    logic [N-1:0]        mirror_pivot;
  } cmd_t;

  cmd_t c;
  assign c = cmd;

  // walk state
  logic                busy;
  logic                steep;
  logic                downward;
  logic [N:0]          walk_major;
  logic [N:0]          walk_minor;
  logic [N:0]          major_end;
  logic signed [N+2:0] decision;
  logic signed [N+1:0] step_east;
  logic signed [N+2:0] step_northeast;
  logic [N-1:0]        mirror_pivot;

  logic                busy_next;
  logic                steep_next;
  logic                downward_next;
  logic [N:0]          walk_major_next;
  logic [N:0]          walk_minor_next;
  logic [N:0]          major_end_next;
  logic signed [N+2:0] decision_next;
  logic signed [N+1:0] step_east_next;
  logic signed [N+2:0] step_northeast_next;
  logic [N-1:0]        mirror_pivot_next;
  logic                emit;

  // output register
  logic         out_valid;
  logic         out_pixel_valid;
  logic [N-1:0] out_x;
  logic [N-1:0] out_y;
  logic         out_last;

  logic         pop;
  logic [N:0]   row_src;
  logic [N:0]   col_src;
  logic [N:0]   mirrored;
  logic [N-1:0] px;
  logic [N-1:0] py;

  assign cmd_ready = !out_valid || pixel_out.ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    busy_next           = busy;
    steep_next          = steep;
    downward_next       = downward;
    walk_major_next     = walk_major;
    walk_minor_next     = walk_minor;
    major_end_next      = major_end;
    decision_next       = decision;
    step_east_next      = step_east;
    step_northeast_next = step_northeast;
    mirror_pivot_next   = mirror_pivot;
    emit                = 1'b0;
    if (c.is_load) begin
      steep_next          = c.steep;
      downward_next       = c.downward;
      walk_major_next     = c.walk_major;
      walk_minor_next     = c.walk_minor;
      major_end_next      = c.major_end;
      decision_next       = c.decision;
      step_east_next      = c.step_east;
      step_northeast_next = c.step_northeast;
      mirror_pivot_next   = c.mirror_pivot;
      busy_next           = c.walk_major != c.major_end;
      emit                = 1'b1;
    end else if (busy) begin
      walk_major_next = walk_major + 1'b1;
      // a tie takes the E step
      if (decision[N+2] || decision == '0) begin
        decision_next = decision + $signed({step_east[N+1], step_east});
      end else begin
        walk_minor_next = walk_minor + 1'b1;
        decision_next   = decision + step_northeast;
      end
      busy_next = walk_major_next != major_end;
      emit      = 1'b1;
    end
  end

  // back to screen space: undo y=x swap, then the fold about the pivot row
  always_comb begin
    col_src  = steep_next ? walk_minor_next : walk_major_next;
    row_src  = steep_next ? walk_major_next : walk_minor_next;
    mirrored = {mirror_pivot_next, 1'b0} - row_src;
    px       = emit ? col_src[N-1:0] : '0;
    py       = !emit ? '0 : (downward_next ? mirrored[N-1:0] : row_src[N-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy      <= busy_next;
        out_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      steep           <= steep_next;
      downward        <= downward_next;
      walk_major      <= walk_major_next;
      walk_minor      <= walk_minor_next;
      major_end       <= major_end_next;
      decision        <= decision_next;
      step_east       <= step_east_next;
      step_northeast  <= step_northeast_next;
      mirror_pivot    <= mirror_pivot_next;
      out_pixel_valid <= emit;
      out_x           <= px;
      out_y           <= py;
      out_last        <= emit && !busy_next;
    end
  end

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_valid = out_pixel_valid;
  assign pixel_out.pixel_x     = out_x;
  assign pixel_out.pixel_y     = out_y;
  assign pixel_out.last        = out_last;

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pixel_valid |-> out_x == '0 && out_y == '0 && !out_last)
    else $error("idle step result carries nonzero fields");

  a_busy_not_at_end: assert property (@(posedge clk) disable iff (rst)
    busy |-> walk_major != major_end)
    else $error("walker busy at its far endpoint");

  a_pixel_when_walking: assert property (@(posedge clk) disable iff (rst)
    pop && (c.is_load || busy) |=> out_valid && out_pixel_valid)
    else $error("load or active step produced no pixel");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy == !(out_last || !out_pixel_valid))
    else $error("last mark disagrees with walker state");

endmodule

// ===== sv/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Integer midpoint line rasterizer with a setup front end, a command FIFO
// and a single-step pixel walker.
// ----------------------------------------------------------------------------
// Every command on line_in (load or step) returns exactly one item on
// pixel_out, in order. A load emits the left endpoint; each step emits the
// next pixel, with last set on the far endpoint; a step with no line active
// returns pixel_valid = 0 and zero fields. One command is taken per clock while
// the FIFO has room, and one result leaves per clock when the sink is ready.
// An accepted command passes the setup register and then a FIFO entry before
// the walker loads the output register; the walker's E/NE decision update sets
// the rate. The FIFO between setup and walker holds QUEUE_DEPTH commands, so
// either side can stall without stopping the other. Both interfaces must be
// built with N equal to COORD_BITS.
module midpoint_line_rasterizer #(
  parameter int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mlr_line_if.sink    line_in,
  mlr_pixel_if.source pixel_out
);
  import mlr_pkg::*;

  localparam int CW = cmd_bits(COORD_BITS);

  logic          f_valid;
  logic          f_ready;
  logic [CW-1:0] f_cmd;
  logic          b_valid;
  logic          b_ready;
  logic [CW-1:0] b_cmd;

  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_in),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  mlr_queue #(.WIDTH(CW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_cmd)
  );

  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd       (b_cmd),
    .cmd_ready (b_ready),
    .pixel_out (pixel_out)
  );

endmodule
